// ===== hw/rtl/cffr_pkg.sv =====
`default_nettype none

package cffr_pkg;

  // Result kinds reported in tuser
  typedef enum logic [2:0] {
    KIND_NOT_ADDR   = 3'd0,
    KIND_HANDLER    = 3'd1,
    KIND_NO_HANDLER = 3'd2,
    KIND_STORED     = 3'd3,
    KIND_SERIAL_OUT = 3'd4,
    KIND_COMMAND    = 3'd5,
    KIND_NO_SLOT    = 3'd6,
    KIND_OVERFLOW   = 3'd7
  } kind_e;

  localparam logic [7:0] BROADCAST_NODE = 8'hFF;

  // Register byte addresses on the configuration port
  localparam int unsigned ADDR_BITS = 4;
  localparam logic [ADDR_BITS-1:0] REG_NODE_ID      = 4'h0;
  localparam logic [ADDR_BITS-1:0] REG_HANDLER_MASK = 4'h8;

  // Commands from the sequencer to the slot table
  typedef struct packed {
    logic       claim;     // mark busy with src and serial kind
    logic       set_fill;  // store a new fill level
    logic       free;      // return the slot to the free pool
    logic       is_cmd;    // serial kind of the frame being handled
    logic [7:0] src;       // source node of the frame being handled
  } slot_cmd_t;

  // Status of the slot under the shared compare unit
  typedef struct packed {
    logic busy;
    logic match;  // busy, same source, same serial kind
  } slot_stat_t;

endpackage

`default_nettype wire

// ===== hw/rtl/cffr_byte_mem.sv =====
`default_nettype none

module cffr_byte_mem #(
  parameter int unsigned ADDR_W = 8
) (
  input  wire logic              clk_i,
  input  wire logic              we_i,
  input  wire logic [ADDR_W-1:0] waddr_i,
  input  wire logic [7:0]        wdata_i,
  input  wire logic              re_i,
  input  wire logic [ADDR_W-1:0] raddr_i,
  output logic      [7:0]        rdata_o
);

  localparam int unsigned DEPTH = 1 << ADDR_W;

  logic [7:0] mem [DEPTH];

  // Write one byte a cycle
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read one byte a cycle, registered
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/cffr_slot_table.sv =====
`default_nettype none

module cffr_slot_table
  import cffr_pkg::*;
#(
  parameter int unsigned SLOT_COUNT = 4,
  parameter int unsigned SLOT_W     = 2,
  parameter int unsigned FILL_W     = 7
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [SLOT_W-1:0] idx_i,
  input  wire slot_cmd_t         cmd_i,
  input  wire logic [FILL_W-1:0] fill_i,
  output slot_stat_t             stat_o,
  output logic      [FILL_W-1:0] fill_o
);

  logic              busy_q   [SLOT_COUNT];
  logic [7:0]        source_q [SLOT_COUNT];
  logic              is_cmd_q [SLOT_COUNT];
  logic [FILL_W-1:0] fill_q   [SLOT_COUNT];

  logic in_range;

  assign in_range = (32'(idx_i) < SLOT_COUNT);

  // Compare the selected slot against the frame key
  always_comb begin
    stat_o = '0;
    fill_o = '0;
    if (in_range) begin
      stat_o.busy  = busy_q[idx_i];
      stat_o.match = busy_q[idx_i] && (source_q[idx_i] == cmd_i.src) &&
                     (is_cmd_q[idx_i] == cmd_i.is_cmd);
      fill_o       = fill_q[idx_i];
    end
  end

  // Update the selected slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOT_COUNT; i++) begin
        busy_q[i]   <= 1'b0;
        source_q[i] <= BROADCAST_NODE;
        is_cmd_q[i] <= 1'b0;
        fill_q[i]   <= '0;
      end
    end else if (in_range) begin
      if (cmd_i.free) begin
        busy_q[idx_i]   <= 1'b0;
        source_q[idx_i] <= BROADCAST_NODE;
        is_cmd_q[idx_i] <= 1'b0;
        fill_q[idx_i]   <= '0;
      end else begin
        if (cmd_i.claim) begin
          busy_q[idx_i]   <= 1'b1;
          source_q[idx_i] <= cmd_i.src;
          is_cmd_q[idx_i] <= cmd_i.is_cmd;
        end
        if (cmd_i.set_fill) begin
          fill_q[idx_i] <= fill_i;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/can_frame_filter_reassembly.sv =====
`default_nettype none

// Receive filter and reassembler for extended CAN frames. One frame enters on the
// slave stream; it yields one result, or for a completed serial message one result
// per 8-byte chunk, with tlast on the final one. A serial frame walks the slot
// table through one shared compare unit, one slot a cycle. A frame that finds a
// slot claims it in ST_CLAIM and, unless it is refused for overflow or is empty,
// writes its bytes into the byte buffer one a cycle (up to 8). A completing frame
// then reads the stored message back one byte at a time through the single buffer
// read port, in ST_READ and then ST_CAPT, and holds each chunk in ST_OUT until it
// is taken. The block takes no new frame until the last result of the current one
// has been taken. node_id sits at byte address 0 and handler_mask at byte address
// 8; both reset to zero. The byte buffer needs no clearing after reset.
module can_frame_filter_reassembly
  import cffr_pkg::*;
#(
  parameter int unsigned SLOT_COUNT     = 4,
  parameter int unsigned BUFFER_BYTES   = 64,
  parameter int unsigned ORDINARY_TYPES = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // APB configuration port
  input  wire logic                 psel,
  input  wire logic                 penable,
  input  wire logic                 pwrite,
  input  wire logic [ADDR_BITS-1:0] paddr,
  input  wire logic [63:0]          pwdata,
  output logic      [63:0]          prdata,
  output logic                      pready,
  // Frame input
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // can_id[28:0], frame_len[32:29], frame_data[96:33], zero[103:97]
  input  wire logic [103:0]         s_axis_tdata,
  // Result output
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // src_node[7:0], dst_node[15:8], msg_type[23:16], slot[25:24],
  // chunk[89:26], chunk_len[93:90], zero[95:94]
  output logic      [95:0]          m_axis_tdata,
  // kind[2:0]
  output logic      [2:0]           m_axis_tuser,
  output logic                      m_axis_tlast
);

  localparam int unsigned SLOT_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int unsigned OFF_W  = $clog2(BUFFER_BYTES);
  localparam int unsigned FILL_W = $clog2(BUFFER_BYTES + 1);
  localparam int unsigned ADDR_W = SLOT_W + OFF_W;

  localparam logic [SLOT_W-1:0] LAST_SLOT   = SLOT_W'(SLOT_COUNT - 1);
  localparam logic [7:0]        TYPE_SERIAL = 8'(ORDINARY_TYPES);
  localparam logic [7:0]        TYPE_CMD    = 8'(ORDINARY_TYPES + 1);
  localparam logic [FILL_W:0]   BUF_LIMIT   = (FILL_W + 1)'(BUFFER_BYTES);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLAIM,
    ST_WRITE,
    ST_READ,
    ST_CAPT,
    ST_OUT
  } state_e;

  state_e state_q;

  // Configuration registers
  logic [7:0]  node_id_q;
  logic [63:0] handler_mask_q;

  // Frame held for the duration of the item
  logic [7:0]  src_q, dst_q, typ_q;
  logic [3:0]  len_q;
  logic [63:0] data_q;   // payload with unused bytes zero
  logic        is_cmd_q;

  // Slot search and buffer pointers
  logic [SLOT_W-1:0] idx_q;
  logic              free_vld_q;
  logic [SLOT_W-1:0] free_idx_q;
  logic [FILL_W-1:0] wr_ptr_q;
  logic [3:0]        wr_cnt_q;
  logic [FILL_W-1:0] fill_q;
  logic [FILL_W-1:0] pos_q;
  logic [2:0]        cnt_q;
  logic              cmpl_q;

  // Output register
  logic        out_valid_q;
  kind_e       out_kind_q;
  logic [1:0]  out_slot_q;
  logic [63:0] out_chunk_q;
  logic [3:0]  out_clen_q;
  logic        out_last_q;

  // Input unpacking
  logic [28:0] in_id;
  logic [3:0]  in_len_raw;
  logic [3:0]  in_len;
  logic [63:0] in_data;
  logic [63:0] in_payload;
  logic [7:0]  in_typ, in_dst;
  logic        in_accept;

  // Slot table and buffer connections
  slot_cmd_t         slot_cmd;
  slot_stat_t        slot_stat;
  logic [FILL_W-1:0] slot_fill;
  logic [FILL_W-1:0] wr_ptr_inc;
  logic [FILL_W:0]   fill_sum;
  logic [7:0]        wr_byte;
  logic              mem_we, mem_re;
  logic [7:0]        mem_rdata;
  logic [FILL_W-1:0] pos_inc;

  // Configuration write and read
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q      <= '0;
      handler_mask_q <= '0;
    end else if (psel && penable && pwrite) begin
      if (paddr[3] == REG_HANDLER_MASK[3]) begin
        handler_mask_q <= pwdata;
      end else begin
        node_id_q <= pwdata[7:0];
      end
    end
  end

  assign pready = 1'b1;
  assign prdata = (paddr[3] == REG_HANDLER_MASK[3]) ? handler_mask_q : {56'd0, node_id_q};

  // Split and clamp the incoming frame
  assign in_id      = s_axis_tdata[28:0];
  assign in_len_raw = s_axis_tdata[32:29];
  assign in_data    = s_axis_tdata[96:33];
  assign in_len     = (in_len_raw > 4'd8) ? 4'd8 : in_len_raw;
  assign in_typ     = in_id[23:16];
  assign in_dst     = in_id[15:8];
  assign in_accept  = s_axis_tvalid && s_axis_tready;

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      in_payload[b*8 +: 8] = (4'(b) < in_len) ? in_data[b*8 +: 8] : 8'd0;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);

  // Slot table control
  assign fill_sum   = (FILL_W + 1)'(slot_fill) + (FILL_W + 1)'(len_q);
  assign wr_ptr_inc = wr_ptr_q + FILL_W'(1);
  assign pos_inc    = pos_q + FILL_W'(1);
  assign wr_byte    = data_q[wr_cnt_q[2:0]*8 +: 8];

  always_comb begin
    slot_cmd          = '0;
    slot_cmd.src      = src_q;
    slot_cmd.is_cmd   = is_cmd_q;
    slot_cmd.claim    = (state_q == ST_CLAIM);
    slot_cmd.set_fill = (state_q == ST_WRITE) && ((wr_cnt_q + 4'd1) == len_q);
    slot_cmd.free     = (state_q == ST_OUT) && m_axis_tready && out_last_q && cmpl_q;
  end

  cffr_slot_table #(
    .SLOT_COUNT (SLOT_COUNT),
    .SLOT_W     (SLOT_W),
    .FILL_W     (FILL_W)
  ) u_slot_table (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .idx_i  (idx_q),
    .cmd_i  (slot_cmd),
    .fill_i (wr_ptr_inc),
    .stat_o (slot_stat),
    .fill_o (slot_fill)
  );

  assign mem_we = (state_q == ST_WRITE);
  assign mem_re = (state_q == ST_READ);

  cffr_byte_mem #(
    .ADDR_W (ADDR_W)
  ) u_byte_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i ({idx_q, wr_ptr_q[OFF_W-1:0]}),
    .wdata_i (wr_byte),
    .re_i    (mem_re),
    .raddr_i ({idx_q, pos_q[OFF_W-1:0]}),
    .rdata_o (mem_rdata)
  );

  // Sequencer and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      out_kind_q  <= KIND_NOT_ADDR;
      out_last_q  <= 1'b0;
      out_slot_q  <= '0;
      out_chunk_q <= '0;
      out_clen_q  <= '0;
      src_q       <= '0;
      dst_q       <= '0;
      typ_q       <= '0;
      len_q       <= '0;
      data_q      <= '0;
      is_cmd_q    <= 1'b0;
      cmpl_q      <= 1'b0;
      free_vld_q  <= 1'b0;
      idx_q       <= '0;
      free_idx_q  <= '0;
      wr_ptr_q    <= '0;
      wr_cnt_q    <= '0;
      fill_q      <= '0;
      pos_q       <= '0;
      cnt_q       <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_accept) begin
            src_q       <= in_id[7:0];
            dst_q       <= in_dst;
            typ_q       <= in_typ;
            len_q       <= in_len;
            data_q      <= in_payload;
            is_cmd_q    <= (in_typ == TYPE_CMD);
            idx_q       <= '0;
            free_vld_q  <= 1'b0;
            cmpl_q      <= 1'b0;
            out_slot_q  <= '0;
            out_chunk_q <= '0;
            out_clen_q  <= '0;
            out_last_q  <= 1'b1;
            priority if (in_dst != BROADCAST_NODE && in_dst != node_id_q) begin
              out_kind_q  <= KIND_NOT_ADDR;
              out_valid_q <= 1'b1;
              state_q     <= ST_OUT;
            end else if (in_typ == TYPE_SERIAL || in_typ == TYPE_CMD) begin
              state_q <= ST_SCAN;
            end else if ((32'(in_typ) < ORDINARY_TYPES) && handler_mask_q[in_typ[5:0]]) begin
              out_kind_q  <= KIND_HANDLER;
              out_chunk_q <= in_payload;
              out_clen_q  <= in_len;
              out_valid_q <= 1'b1;
              state_q     <= ST_OUT;
            end else begin
              out_kind_q  <= KIND_NO_HANDLER;
              out_valid_q <= 1'b1;
              state_q     <= ST_OUT;
            end
          end
        end

        // Walk the slots: first matching slot wins, else the lowest free one
        ST_SCAN: begin
          if (slot_stat.match) begin
            state_q <= ST_CLAIM;
          end else begin
            if (!slot_stat.busy && !free_vld_q) begin
              free_vld_q <= 1'b1;
              free_idx_q <= idx_q;
            end
            if (idx_q == LAST_SLOT) begin
              if (free_vld_q) begin
                idx_q   <= free_idx_q;
                state_q <= ST_CLAIM;
              end else if (!slot_stat.busy) begin
                state_q <= ST_CLAIM;
              end else begin
                out_kind_q  <= KIND_NO_SLOT;
                out_valid_q <= 1'b1;
                state_q     <= ST_OUT;
              end
            end else begin
              idx_q <= idx_q + SLOT_W'(1);
            end
          end
        end

        // Claim the slot, then refuse, store nothing, or start appending
        ST_CLAIM: begin
          out_slot_q <= 2'(idx_q);
          priority if (fill_sum > BUF_LIMIT) begin
            out_kind_q  <= KIND_OVERFLOW;
            out_valid_q <= 1'b1;
            state_q     <= ST_OUT;
          end else if (len_q == 4'd0) begin
            out_kind_q  <= KIND_STORED;
            out_valid_q <= 1'b1;
            state_q     <= ST_OUT;
          end else begin
            wr_ptr_q <= slot_fill;
            wr_cnt_q <= '0;
            state_q  <= ST_WRITE;
          end
        end

        // Append one byte a cycle
        ST_WRITE: begin
          wr_ptr_q <= wr_ptr_inc;
          wr_cnt_q <= wr_cnt_q + 4'd1;
          if ((wr_cnt_q + 4'd1) == len_q) begin
            if (wr_byte != 8'd0) begin
              out_kind_q  <= KIND_STORED;
              out_chunk_q <= data_q;
              out_clen_q  <= len_q;
              out_valid_q <= 1'b1;
              state_q     <= ST_OUT;
            end else begin
              out_kind_q  <= is_cmd_q ? KIND_COMMAND : KIND_SERIAL_OUT;
              fill_q      <= wr_ptr_inc;
              pos_q       <= '0;
              cnt_q       <= '0;
              cmpl_q      <= 1'b1;
              out_last_q  <= 1'b0;
              state_q     <= ST_READ;
            end
          end
        end

        ST_READ: begin
          state_q <= ST_CAPT;
        end

        // Pack the read byte, emit at eight bytes or at the end of the message
        ST_CAPT: begin
          out_chunk_q[cnt_q*8 +: 8] <= mem_rdata;
          pos_q <= pos_inc;
          cnt_q <= cnt_q + 3'd1;
          if (cnt_q == 3'd7 || pos_inc == fill_q) begin
            out_clen_q  <= 4'(cnt_q) + 4'd1;
            out_last_q  <= (pos_inc == fill_q);
            out_valid_q <= 1'b1;
            state_q     <= ST_OUT;
          end else begin
            state_q <= ST_READ;
          end
        end

        // Hold the result until taken
        ST_OUT: begin
          if (m_axis_tready) begin
            out_valid_q <= 1'b0;
            if (out_last_q) begin
              state_q <= ST_IDLE;
            end else begin
              out_chunk_q <= '0;
              cnt_q       <= '0;
              state_q     <= ST_READ;
            end
          end
        end

        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_kind_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {2'b00, out_clen_q, out_chunk_q, out_slot_q, typ_q, dst_q, src_q};

endmodule

`default_nettype wire

// ===== dv/tb_can_frame_filter_reassembly.sv =====
`timescale 1ns / 1ps

module tb_can_frame_filter_reassembly;
  import cffr_pkg::*;

  localparam int unsigned SLOTS           = 4;
  localparam int unsigned BUF_BYTES       = 64;
  localparam int unsigned ORD_TYPES       = 64;
  localparam logic [7:0]  SERIAL_TYPE     = 8'(ORD_TYPES);
  localparam logic [7:0]  COMMAND_TYPE    = 8'(ORD_TYPES + 1);
  localparam logic [7:0]  DIRECTED_NODE   = 8'h5A;
  localparam int unsigned RANDOM_PHASES   = 6;
  localparam int unsigned ITEMS_PER_PHASE = 26;
  localparam int unsigned CYCLE_LIMIT     = 400000;
  localparam int unsigned MAX_REPORTS     = 60;

  // One result item as it leaves the block
  typedef struct {
    kind_e       kind;
    logic [7:0]  src;
    logic [7:0]  dst;
    logic [7:0]  typ;
    logic [1:0]  slot;
    logic [63:0] chunk;
    logic [3:0]  clen;
    logic        is_final;
  } result_t;

  // One row of frame stimulus; a config row carries register values instead
  typedef struct {
    bit          set_cfg;
    logic [7:0]  cfg_node;
    logic [63:0] cfg_mask;
    logic [28:0] can_id;
    logic [3:0]  len;
    logic [63:0] data;
    bit          typed;
    kind_e       kind;
    logic [1:0]  slot;
    logic [63:0] chunk;
    logic [3:0]  clen;
  } frame_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [ADDR_BITS-1:0] paddr;
  logic [63:0]          pwdata;
  logic [63:0]          prdata;
  logic                 pready;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // can_id[28:0], frame_len[32:29], frame_data[96:33], zero[103:97]
  logic [103:0]         s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // src_node[7:0], dst_node[15:8], msg_type[23:16], slot[25:24],
  // chunk[89:26], chunk_len[93:90], zero[95:94]
  logic [95:0]          m_axis_tdata;
  // kind[2:0]
  logic [2:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  // Shadow copy of the registers and the slot table
  logic [7:0]  node_q;
  logic [63:0] mask_q;
  bit          slot_busy [SLOTS];
  logic [7:0]  slot_src  [SLOTS];
  bit          slot_cmd  [SLOTS];
  int unsigned slot_fill [SLOTS];
  logic [7:0]  slot_mem  [SLOTS][BUF_BYTES];

  result_t     pending_results[$];
  frame_row_t  directed_frames[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  bit          steady;

  can_frame_filter_reassembly uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic logic [28:0] frame_id(logic [7:0] typ, logic [7:0] dst, logic [7:0] src);
    return {5'd0, typ, dst, src};
  endfunction

  // Keep only the first len bytes of the frame data
  function automatic logic [63:0] frame_payload(logic [63:0] data, int unsigned len);
    if (len >= 8) return data;
    return data & ((64'd1 << (8 * len)) - 64'd1);
  endfunction

  function automatic void add_result(kind_e kind, logic [7:0] src, logic [7:0] dst,
                                     logic [7:0] typ, logic [1:0] slot, logic [63:0] chunk,
                                     logic [3:0] clen, logic is_final);
    result_t r;
    r.kind     = kind;
    r.src      = src;
    r.dst      = dst;
    r.typ      = typ;
    r.slot     = slot;
    r.chunk    = chunk;
    r.clen     = clen;
    r.is_final = is_final;
    pending_results.push_back(r);
  endfunction

  // Filter, reassemble and queue the results of one frame; return their count
  function automatic int predict_frame(logic [28:0] id, logic [3:0] len_in, logic [63:0] data);
    logic [7:0]  typ;
    logic [7:0]  dst;
    logic [7:0]  src;
    logic [63:0] c;
    int unsigned len;
    int unsigned fill;
    int unsigned pos;
    int unsigned n;
    int          sel;
    int          i;
    int          count;
    bit          is_cmd;
    typ = id[23:16];
    dst = id[15:8];
    src = id[7:0];
    len = (len_in > 4'd8) ? 8 : int'(len_in);

    // Drop frames for other nodes
    if (dst != BROADCAST_NODE && dst != node_q) begin
      add_result(KIND_NOT_ADDR, src, dst, typ, 2'd0, 64'd0, 4'd0, 1'b1);
      return 1;
    end

    // Ordinary types go to a handler when one is registered
    if (typ != SERIAL_TYPE && typ != COMMAND_TYPE) begin
      if (typ < ORD_TYPES && mask_q[typ[5:0]])
        add_result(KIND_HANDLER, src, dst, typ, 2'd0, frame_payload(data, len), 4'(len),
                   1'b1);
      else
        add_result(KIND_NO_HANDLER, src, dst, typ, 2'd0, 64'd0, 4'd0, 1'b1);
      return 1;
    end

    // Find the matching slot, else the lowest free one
    is_cmd = (typ == COMMAND_TYPE);
    sel = -1;
    for (i = 0; i < SLOTS; i++)
      if (sel < 0 && slot_busy[i] && slot_src[i] == src && slot_cmd[i] == is_cmd) sel = i;
    for (i = 0; i < SLOTS; i++)
      if (sel < 0 && !slot_busy[i]) sel = i;
    if (sel < 0) begin
      add_result(KIND_NO_SLOT, src, dst, typ, 2'd0, 64'd0, 4'd0, 1'b1);
      return 1;
    end

    slot_busy[sel] = 1'b1;
    slot_src[sel]  = src;
    slot_cmd[sel]  = is_cmd;
    fill = slot_fill[sel];
    if (fill + len > BUF_BYTES) begin
      add_result(KIND_OVERFLOW, src, dst, typ, 2'(sel), 64'd0, 4'd0, 1'b1);
      return 1;
    end

    // Append the bytes
    for (i = 0; i < len; i++) slot_mem[sel][fill + i] = data[8 * i +: 8];
    fill += len;
    slot_fill[sel] = fill;
    if (len == 0 || slot_mem[sel][fill - 1] != 8'd0) begin
      add_result(KIND_STORED, src, dst, typ, 2'(sel), frame_payload(data, len), 4'(len), 1'b1);
      return 1;
    end

    // Message complete: emit it in 8-byte chunks and free the slot
    pos = 0;
    count = 0;
    while (pos < fill) begin
      n = (fill - pos > 8) ? 8 : fill - pos;
      c = 64'd0;
      for (i = 0; i < n; i++) c[8 * i +: 8] = slot_mem[sel][pos + i];
      pos += n;
      add_result(is_cmd ? KIND_COMMAND : KIND_SERIAL_OUT, src, dst, typ, 2'(sel), c, 4'(n),
                 pos >= fill);
      count++;
    end
    slot_busy[sel] = 1'b0;
    slot_src[sel]  = BROADCAST_NODE;
    slot_cmd[sel]  = 1'b0;
    slot_fill[sel] = 0;
    return count;
  endfunction

  function automatic void compare_field(string name, logic [63:0] want, logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
    end
  endfunction

  // Compare one accepted result with the oldest expectation
  function automatic void check_result();
    result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= MAX_REPORTS)
        $display("%0t: result with nothing pending, kind %0d tdata %h", $time,
                 m_axis_tuser, m_axis_tdata);
      return;
    end
    want = pending_results.pop_front();
    compare_field("kind", 64'(want.kind), 64'(m_axis_tuser));
    compare_field("src_node", 64'(want.src), 64'(m_axis_tdata[7:0]));
    compare_field("dst_node", 64'(want.dst), 64'(m_axis_tdata[15:8]));
    compare_field("msg_type", 64'(want.typ), 64'(m_axis_tdata[23:16]));
    compare_field("slot", 64'(want.slot), 64'(m_axis_tdata[25:24]));
    compare_field("chunk", want.chunk, m_axis_tdata[89:26]);
    compare_field("chunk_len", 64'(want.clen), 64'(m_axis_tdata[93:90]));
    compare_field("last", 64'(want.is_final), 64'(m_axis_tlast));
  endfunction

  function automatic void add_cfg(logic [7:0] node, logic [63:0] mask);
    frame_row_t f;
    f.set_cfg  = 1'b1;
    f.cfg_node = node;
    f.cfg_mask = mask;
    f.typed    = 1'b0;
    f.kind     = KIND_NOT_ADDR;
    directed_frames.push_back(f);
  endfunction

  function automatic void add_typed(logic [28:0] id, logic [3:0] len, logic [63:0] data,
                                    kind_e kind, logic [1:0] slot, logic [63:0] chunk,
                                    logic [3:0] clen);
    frame_row_t f;
    f.set_cfg = 1'b0;
    f.can_id  = id;
    f.len     = len;
    f.data    = data;
    f.typed   = 1'b1;
    f.kind    = kind;
    f.slot    = slot;
    f.chunk   = chunk;
    f.clen    = clen;
    directed_frames.push_back(f);
  endfunction

  function automatic void add_frame(logic [28:0] id, logic [3:0] len, logic [63:0] data);
    add_typed(id, len, data, KIND_NOT_ADDR, 2'd0, 64'd0, 4'd0);
    directed_frames[$].typed = 1'b0;
  endfunction

  // Write a register over APB, then read it back
  task automatic write_reg(input logic [ADDR_BITS-1:0] addr, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    compare_field("prdata", value, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Wait for the block to drain, then load both registers
  task automatic apply_config(input logic [7:0] node, input logic [63:0] mask);
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    write_reg(REG_NODE_ID, {56'd0, node});
    write_reg(REG_HANDLER_MASK, mask);
    node_q = node;
    mask_q = mask;
  endtask

  // Offer one frame, hold it until taken, then predict its results
  task automatic send_frame(input frame_row_t f);
    int count;
    result_t r;
    while (!steady && $urandom_range(0, 99) < 25) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, f.data, f.len, f.can_id};
    do @(posedge clk_i); while (!s_axis_tready);
    count = predict_frame(f.can_id, f.len, f.data);
    if (f.typed) begin
      // replace the prediction with the hand-written result
      repeat (count) void'(pending_results.pop_back());
      r.kind     = f.kind;
      r.src      = f.can_id[7:0];
      r.dst      = f.can_id[15:8];
      r.typ      = f.can_id[23:16];
      r.slot     = f.slot;
      r.chunk    = f.chunk;
      r.clen     = f.clen;
      r.is_final = 1'b1;
      pending_results.push_back(r);
    end
  endtask

  // Mostly well-formed serial traffic from a few sources, plus other types and noise
  task automatic random_frame(output frame_row_t f);
    int unsigned pick;
    int unsigned eff;
    logic [7:0]  typ;
    logic [7:0]  dst;
    logic [7:0]  src;
    f.set_cfg = 1'b0;
    f.typed   = 1'b0;
    f.kind    = KIND_NOT_ADDR;
    f.data    = {$urandom, $urandom};
    f.len     = 4'($urandom_range(1, 8));
    dst  = ($urandom_range(0, 3) == 0) ? BROADCAST_NODE : node_q;
    src  = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 55) begin
      typ = ($urandom_range(0, 2) == 0) ? COMMAND_TYPE : SERIAL_TYPE;
      src = 8'(8'h20 + $urandom_range(0, 7));
      case ($urandom_range(0, 19))
        0: f.len = 4'd0;
        1: f.len = 4'($urandom_range(9, 15));
        default: ;
      endcase
      eff = (f.len > 4'd8) ? 8 : int'(f.len);
      if (eff != 0) begin
        if ($urandom_range(0, 3) == 0) f.data[8 * (eff - 1) +: 8] = 8'h00;
        else if (f.data[8 * (eff - 1) +: 8] == 8'h00) f.data[8 * (eff - 1) +: 8] = 8'hA5;
      end
    end else if (pick < 80) begin
      typ   = 8'($urandom_range(0, ORD_TYPES - 1));
      f.len = 4'($urandom_range(0, 15));
    end else if (pick < 88) begin
      typ = 8'($urandom_range(ORD_TYPES + 2, 255));
    end else begin
      typ   = 8'($urandom);
      dst   = 8'($urandom);
      f.len = 4'($urandom_range(0, 15));
    end
    f.can_id = {5'($urandom), typ, dst, src};
  endtask

  // Result side: check each accepted item, stall at random
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) check_result();
      m_axis_tready <= steady || ($urandom_range(0, 99) >= 25);
    end
  end

  // Watchdog
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("%0t: timeout with %0d results pending", $time, pending_results.size());
    $display("tb_can_frame_filter_reassembly NOT OK");
    $finish;
  end

  initial begin
    frame_row_t f;
    int         p;
    int         i;
    mismatches    = 0;
    steady        = 1'b0;
    rst_ni        <= 1'b0;
    psel          <= 1'b0;
    penable       <= 1'b0;
    pwrite        <= 1'b0;
    paddr         <= '0;
    pwdata        <= '0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;

    // Shadow state after reset
    node_q = 8'd0;
    mask_q = 64'd0;
    for (i = 0; i < SLOTS; i++) begin
      slot_busy[i] = 1'b0;
      slot_src[i]  = BROADCAST_NODE;
      slot_cmd[i]  = 1'b0;
      slot_fill[i] = 0;
    end

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset state: node 0, no handlers
    add_typed(frame_id(8'd5, 8'h12, 8'h33), 4'd8, 64'h1122334455667788,
              KIND_NOT_ADDR, 2'd0, 64'd0, 4'd0);
    add_typed(frame_id(8'd0, 8'h00, 8'h01), 4'd8, 64'h0102030405060708,
              KIND_NO_HANDLER, 2'd0, 64'd0, 4'd0);
    add_typed(frame_id(8'hFF, 8'hFF, 8'hFF) | 29'h1F000000, 4'd15, '1,
              KIND_NO_HANDLER, 2'd0, 64'd0, 4'd0);

    // All handlers registered; ordinary types, overlong and empty frames, an unhandled type and a misaddressed frame
    add_cfg(DIRECTED_NODE, '1);
    add_typed(frame_id(8'd0, DIRECTED_NODE, 8'h00), 4'd8, '1, KIND_HANDLER, 2'd0, '1, 4'd8);
    add_typed(frame_id(8'd63, 8'hFF, 8'h10), 4'd15, 64'h0123456789ABCDEF,
              KIND_HANDLER, 2'd0, 64'h0123456789ABCDEF, 4'd8);
    add_typed(frame_id(8'd7, DIRECTED_NODE, 8'h10), 4'd0, 64'hDEADBEEFDEADBEEF,
              KIND_HANDLER, 2'd0, 64'd0, 4'd0);
    add_typed(frame_id(8'd3, DIRECTED_NODE, 8'h10), 4'd3, 64'hAABBCCDD,
              KIND_HANDLER, 2'd0, 64'hBBCCDD, 4'd3);
    add_typed(frame_id(COMMAND_TYPE + 8'd1, DIRECTED_NODE, 8'h10), 4'd8, 64'h55,
              KIND_NO_HANDLER, 2'd0, 64'd0, 4'd0);
    add_typed(frame_id(8'd0, 8'h00, 8'h10), 4'd8, 64'h55, KIND_NOT_ADDR, 2'd0, 64'd0, 4'd0);

    // Two-frame serial message, then an empty command frame claiming a slot
    add_typed(frame_id(SERIAL_TYPE, DIRECTED_NODE, 8'h21), 4'd8, 64'h0807060504030201,
              KIND_STORED, 2'd0, 64'h0807060504030201, 4'd8);
    add_frame(frame_id(SERIAL_TYPE, DIRECTED_NODE, 8'h21), 4'd3, 64'hFF00_0B0A);
    add_typed(frame_id(COMMAND_TYPE, DIRECTED_NODE, 8'h21), 4'd0, 64'h77,
              KIND_STORED, 2'd0, 64'd0, 4'd0);

    // Fill the remaining slots, then one frame finds no slot and the command message completes
    add_typed(frame_id(SERIAL_TYPE, 8'hFF, 8'h21), 4'd8, 64'h1111111111111111,
              KIND_STORED, 2'd1, 64'h1111111111111111, 4'd8);
    add_typed(frame_id(SERIAL_TYPE, DIRECTED_NODE, 8'h22), 4'd8, 64'h2222222222222222,
              KIND_STORED, 2'd2, 64'h2222222222222222, 4'd8);
    add_typed(frame_id(SERIAL_TYPE, DIRECTED_NODE, 8'h23), 4'd1, 64'h77,
              KIND_STORED, 2'd3, 64'h77, 4'd1);
    add_typed(frame_id(COMMAND_TYPE, DIRECTED_NODE, 8'h24), 4'd1, 64'h01,
              KIND_NO_SLOT, 2'd0, 64'd0, 4'd0);
    add_frame(frame_id(COMMAND_TYPE, DIRECTED_NODE, 8'h21), 4'd8, 64'h00FFFFFFFFFFFFFF);

    // Grow one message to the buffer limit: overflow, then an eight-chunk completion
    repeat (6) add_frame(frame_id(SERIAL_TYPE, DIRECTED_NODE, 8'h21), 4'd8,
                         64'h1111111111111111);
    add_frame(frame_id(SERIAL_TYPE, DIRECTED_NODE, 8'h21), 4'd1, 64'h42);
    add_typed(frame_id(SERIAL_TYPE, DIRECTED_NODE, 8'h21), 4'd8, '1,
              KIND_OVERFLOW, 2'd1, 64'd0, 4'd0);
    add_frame(frame_id(SERIAL_TYPE, DIRECTED_NODE, 8'h21), 4'd7, 64'h0000333333333333);

    foreach (directed_frames[k]) begin
      if (directed_frames[k].set_cfg)
        apply_config(directed_frames[k].cfg_node, directed_frames[k].cfg_mask);
      else
        send_frame(directed_frames[k]);
    end

    // Random traffic over several register settings, the extremes first
    for (p = 0; p < RANDOM_PHASES; p++) begin
      steady = 1'b0;
      case (p)
        0: apply_config(8'd254, 64'd0);
        1: apply_config(8'd0, '1);
        default: apply_config(8'($urandom_range(0, 254)), {$urandom, $urandom});
      endcase
      steady = (p == 2);
      repeat (ITEMS_PER_PHASE) begin
        random_frame(f);
        send_frame(f);
      end
    end

    // Drain and let any stray result show up
    steady = 1'b0;
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("tb_can_frame_filter_reassembly OK");
    end else begin
      $display("tb_can_frame_filter_reassembly NOT OK");
    end
    $finish;
  end

endmodule
